// File: rtl/lsc_pkg.sv
package lsc_pkg;

  // outcode bits, one per window edge
  localparam int unsigned OC_BITS = 4;
  localparam logic [OC_BITS-1:0] OC_TOP    = 4'b0001;
  localparam logic [OC_BITS-1:0] OC_BOTTOM = 4'b0010;
  localparam logic [OC_BITS-1:0] OC_RIGHT  = 4'b0100;
  localparam logic [OC_BITS-1:0] OC_LEFT   = 4'b1000;

  // window edge being clipped against
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  // register indexes of the config port
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_XMIN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_YMIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_XMAX = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_YMAX = 2'd3;

  // clipping passes before a segment is given up
  localparam int unsigned PASS_BITS = 5;
  localparam logic [PASS_BITS-1:0] MAX_PASSES = 5'd16;

  // request to the multiply-divide unit
  typedef struct packed {
    logic start;
    logic neg;
  } lsc_md_req_t;

endpackage

// File: rtl/lsc_muldiv.sv
module lsc_muldiv import lsc_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsc_md_req_t       req_i,
  input  logic [W-1:0]      mag_a_i,
  input  logic [W-1:0]      mag_b_i,
  input  logic [W-1:0]      mag_d_i,
  output logic              done_o,
  output logic signed [W:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [2*W-1:0]    prod_q, prod_d;
  logic [W-1:0]      dvs_q, dvs_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-1:0]      lo_q, lo_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic signed [W:0] quo_q, quo_d;

  logic [W:0]        trial;
  logic [W:0]        trial_diff;
  logic              ge;
  logic [W:0]        qfin;

  // one restoring step per cycle, quotient shifts into the low word
  assign trial      = {rem_q, lo_q[W-1]};
  assign ge         = trial >= {1'b0, dvs_q};
  assign trial_diff = trial - {1'b0, dvs_q};
  assign qfin       = {1'b0, lo_q[W-2:0], ge};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    quo_d   = quo_q;
    case (phase_q)
      P_IDLE: begin
        if (req_i.start) begin
          prod_d  = {{W{1'b0}}, mag_a_i} * {{W{1'b0}}, mag_b_i};
          dvs_d   = mag_d_i;
          neg_d   = req_i.neg;
          phase_d = P_MUL;
        end
      end
      P_MUL: begin
        // high word is below the divisor, so the quotient fits W bits
        rem_d   = prod_q[2*W-1:W];
        lo_d    = prod_q[W-1:0];
        cnt_d   = '0;
        phase_d = P_DIV;
      end
      P_DIV: begin
        rem_d = ge ? trial_diff[W-1:0] : trial[W-1:0];
        lo_d  = {lo_q[W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          done_d  = 1'b1;
          quo_d   = neg_q ? -$signed(qfin) : $signed(qfin);
          phase_d = P_IDLE;
        end
      end
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    neg_q  <= neg_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/line_segment_clipper_unit.sv
// channel   direction  ports                                            handshake
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i                  write when cfg_we_i
// segment   in         start_x_i, start_y_i, end_x_i, end_y_i           start_i && !busy_o
// result    out        visible_o, clip_start_x_o .. clip_end_y_o        valid_o, one cycle
//
// each clipping pass runs the outcode test and operand setup, then waits on the multiply and
// serial divide unit (one restoring step per cycle); a pass whose segment runs parallel to
// the edge skips the unit. a segment takes at most 16 passes.
// rst_ni clears the sequencer and loads the default window, no clearing pass.
// busy_o stays high while an item is in work; the result strobe cannot be stalled and
// the next item may start in the cycle the result is shown.
module line_segment_clipper_unit import lsc_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         valid_o,
  output logic                         visible_o,
  output logic signed [COORD_BITS-1:0] clip_start_x_o,
  output logic signed [COORD_BITS-1:0] clip_start_y_o,
  output logic signed [COORD_BITS-1:0] clip_end_x_o,
  output logic signed [COORD_BITS-1:0] clip_end_y_o
);

  localparam int unsigned W = COORD_BITS;
  localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TEST  = 2'd1;
  localparam logic [1:0] S_SETUP = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [PASS_BITS-1:0]  pass_q, pass_d;
  logic signed [W-1:0]   xmin_q, ymin_q, xmax_q, ymax_q;
  logic signed [W-1:0]   x1_q, y1_q, x2_q, y2_q;
  logic signed [W-1:0]   x1_d, y1_d, x2_d, y2_d;
  logic                  sel_q, sel_d;
  logic [1:0]            edge_q, edge_d;
  logic                  valid_q, valid_d;
  logic                  vis_q, vis_d;
  logic signed [W-1:0]   ox1_q, oy1_q, ox2_q, oy2_q;
  logic signed [W-1:0]   ox1_d, oy1_d, ox2_d, oy2_d;

  logic [OC_BITS-1:0]    c1, c2, csel;
  logic signed [W-1:0]   px, py, qx, qy;
  logic                  yedge;
  logic signed [W-1:0]   p_along, p_cross, q_along, q_cross, edge_val;
  logic signed [W:0]     diff_a, diff_b, diff_d;
  logic [W:0]            abs_a, abs_b, abs_d;
  logic                  div_nz;
  logic signed [W:0]     along_sum;
  logic                  wr_cross, wr_along;
  logic signed [W-1:0]   new_along;

  lsc_md_req_t           md_req;
  logic                  md_done;
  logic signed [W:0]     md_quo;

  // outcodes of both current endpoints
  always_comb begin
    c1 = '0;
    c2 = '0;
    if (y1_q > ymax_q) c1 = c1 | OC_TOP;
    if (y1_q < ymin_q) c1 = c1 | OC_BOTTOM;
    if (x1_q > xmax_q) c1 = c1 | OC_RIGHT;
    if (x1_q < xmin_q) c1 = c1 | OC_LEFT;
    if (y2_q > ymax_q) c2 = c2 | OC_TOP;
    if (y2_q < ymin_q) c2 = c2 | OC_BOTTOM;
    if (x2_q > xmax_q) c2 = c2 | OC_RIGHT;
    if (x2_q < xmin_q) c2 = c2 | OC_LEFT;
    csel = (c1 != '0) ? c1 : c2;
  end

  // operands of the intersection for the chosen point and edge
  always_comb begin
    px = sel_q ? x2_q : x1_q;
    py = sel_q ? y2_q : y1_q;
    qx = sel_q ? x1_q : x2_q;
    qy = sel_q ? y1_q : y2_q;
    yedge = (edge_q == EDGE_TOP) || (edge_q == EDGE_BOTTOM);
    p_along = yedge ? px : py;
    p_cross = yedge ? py : px;
    q_along = yedge ? qx : qy;
    q_cross = yedge ? qy : qx;
    case (edge_q)
      EDGE_TOP:    edge_val = ymax_q;
      EDGE_BOTTOM: edge_val = ymin_q;
      EDGE_RIGHT:  edge_val = xmax_q;
      EDGE_LEFT:   edge_val = xmin_q;
      default:     edge_val = ymax_q;
    endcase
    diff_a = {q_along[W-1], q_along} - {p_along[W-1], p_along};
    diff_b = {edge_val[W-1], edge_val} - {p_cross[W-1], p_cross};
    diff_d = {q_cross[W-1], q_cross} - {p_cross[W-1], p_cross};
    abs_a  = diff_a[W] ? -diff_a : diff_a;
    abs_b  = diff_b[W] ? -diff_b : diff_b;
    abs_d  = diff_d[W] ? -diff_d : diff_d;
    div_nz = diff_d != '0;
    along_sum = {p_along[W-1], p_along} + md_quo;
    new_along = along_sum[W-1:0];
  end

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    sel_d   = sel_q;
    edge_d  = edge_q;
    valid_d = 1'b0;
    vis_d   = vis_q;
    ox1_d   = ox1_q;
    oy1_d   = oy1_q;
    ox2_d   = ox2_q;
    oy2_d   = oy2_q;
    md_req.start = 1'b0;
    md_req.neg   = diff_a[W] ^ diff_b[W] ^ diff_d[W];
    wr_cross = 1'b0;
    wr_along = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          pass_d  = '0;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        // out of passes only counts when the segment is still unsettled
        if ((c1 & c2) != '0 || ((c1 | c2) != '0 && pass_q == MAX_PASSES)) begin
          valid_d = 1'b1;
          vis_d   = 1'b0;
          ox1_d   = '0;
          oy1_d   = '0;
          ox2_d   = '0;
          oy2_d   = '0;
          state_d = S_IDLE;
        end else if ((c1 | c2) == '0) begin
          valid_d = 1'b1;
          vis_d   = 1'b1;
          ox1_d   = x1_q;
          oy1_d   = y1_q;
          ox2_d   = x2_q;
          oy2_d   = y2_q;
          state_d = S_IDLE;
        end else begin
          sel_d = (c1 == '0);
          if ((csel & OC_TOP) != '0)         edge_d = EDGE_TOP;
          else if ((csel & OC_BOTTOM) != '0) edge_d = EDGE_BOTTOM;
          else if ((csel & OC_RIGHT) != '0)  edge_d = EDGE_RIGHT;
          else                               edge_d = EDGE_LEFT;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        if (div_nz) begin
          md_req.start = 1'b1;
          state_d = S_WAIT;
        end else begin
          // segment parallel to the edge: only the crossing coordinate moves
          wr_cross = 1'b1;
          pass_d   = pass_q + 1'b1;
          state_d  = S_TEST;
        end
      end
      S_WAIT: begin
        if (md_done) begin
          wr_cross = 1'b1;
          wr_along = 1'b1;
          pass_d   = pass_q + 1'b1;
          state_d  = S_TEST;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // endpoint update
  always_comb begin
    x1_d = x1_q;
    y1_d = y1_q;
    x2_d = x2_q;
    y2_d = y2_q;
    if (state_q == S_IDLE && start_i) begin
      x1_d = start_x_i;
      y1_d = start_y_i;
      x2_d = end_x_i;
      y2_d = end_y_i;
    end else begin
      if (wr_cross) begin
        case ({sel_q, yedge})
          2'b01:   y1_d = edge_val;
          2'b00:   x1_d = edge_val;
          2'b11:   y2_d = edge_val;
          default: x2_d = edge_val;
        endcase
      end
      if (wr_along) begin
        case ({sel_q, yedge})
          2'b01:   x1_d = new_along;
          2'b00:   y1_d = new_along;
          2'b11:   x2_d = new_along;
          default: y2_d = new_along;
        endcase
      end
    end
  end

  lsc_muldiv #(
    .W(W)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (md_req),
    .mag_a_i (abs_a[W-1:0]),
    .mag_b_i (abs_b[W-1:0]),
    .mag_d_i (abs_d[W-1:0]),
    .done_o  (md_done),
    .quo_o   (md_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= '0;
      valid_q <= 1'b0;
      xmin_q  <= '0;
      ymin_q  <= '0;
      xmax_q  <= COORD_MAX;
      ymax_q  <= COORD_MAX;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_XMIN: xmin_q <= cfg_data_i;
          CFG_YMIN: ymin_q <= cfg_data_i;
          CFG_XMAX: xmax_q <= cfg_data_i;
          CFG_YMAX: ymax_q <= cfg_data_i;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    x2_q   <= x2_d;
    y2_q   <= y2_d;
    sel_q  <= sel_d;
    edge_q <= edge_d;
    vis_q  <= vis_d;
    ox1_q  <= ox1_d;
    oy1_q  <= oy1_d;
    ox2_q  <= ox2_d;
    oy2_q  <= oy2_d;
  end

  assign busy_o         = state_q != S_IDLE;
  assign valid_o        = valid_q;
  assign visible_o      = vis_q;
  assign clip_start_x_o = ox1_q;
  assign clip_start_y_o = oy1_q;
  assign clip_end_x_o   = ox2_q;
  assign clip_end_y_o   = oy2_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result shown while an item is still in work");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not start the sequencer");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !visible_o) |-> (clip_start_x_o == '0 && clip_start_y_o == '0 &&
                                 clip_end_x_o == '0 && clip_end_y_o == '0))
    else $error("rejected segment carries nonzero coordinates");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (pass_q < MAX_PASSES))
    else $error("clipping pass started beyond the pass limit");

  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == S_WAIT))
    else $error("divide unit finished outside the wait state");

endmodule

// File: tb/sv/tb.sv
module tb;
  import lsc_pkg::*;

  localparam int unsigned COORD_BITS  = 16;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          PHASE_ITEMS = 231;
  localparam longint      COORD_MIN   = -32768;
  localparam longint      COORD_MAX   = 32767;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  class clip_scoreboard;
    typedef struct {
      logic   visible;
      coord_t sx;
      coord_t sy;
      coord_t ex;
      coord_t ey;
    } clip_result_t;

    longint left_edge, bottom_edge, right_edge, top_edge;
    clip_result_t pending[$];
    int errors, n_segments, n_results, n_visible;

    function new();
      left_edge   = 0;
      bottom_edge = 0;
      right_edge  = COORD_MAX;
      top_edge    = COORD_MAX;
    endfunction

    function void set_edge(cfg_idx_t idx, coord_t val);
      case (idx)
        CFG_XMIN: left_edge   = val;
        CFG_YMIN: bottom_edge = val;
        CFG_XMAX: right_edge  = val;
        CFG_YMAX: top_edge    = val;
        default: ;
      endcase
    endfunction

    function logic [OC_BITS-1:0] region(longint x, longint y);
      logic [OC_BITS-1:0] code;
      code = '0;
      if (y > top_edge)    code |= OC_TOP;
      if (y < bottom_edge) code |= OC_BOTTOM;
      if (x > right_edge)  code |= OC_RIGHT;
      if (x < left_edge)   code |= OC_LEFT;
      return code;
    endfunction

    // slide (px,py) toward (qx,qy) onto the first edge named in its code
    function void move_to_edge(ref longint px, ref longint py,
                               input longint qx, input longint qy,
                               input logic [OC_BITS-1:0] code);
      longint x, y;
      x = px;
      y = py;
      if ((code & OC_TOP) != 0) begin
        if (qy != y) px = x + ((qx - x) * (top_edge - y)) / (qy - y);
        py = top_edge;
      end else if ((code & OC_BOTTOM) != 0) begin
        if (qy != y) px = x + ((qx - x) * (bottom_edge - y)) / (qy - y);
        py = bottom_edge;
      end else if ((code & OC_RIGHT) != 0) begin
        if (qx != x) py = y + ((qy - y) * (right_edge - x)) / (qx - x);
        px = right_edge;
      end else if ((code & OC_LEFT) != 0) begin
        if (qx != x) py = y + ((qy - y) * (left_edge - x)) / (qx - x);
        px = left_edge;
      end
    endfunction

    function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      longint x1, y1, x2, y2;
      logic [OC_BITS-1:0] c1, c2;
      bit shown;
      clip_result_t res;
      x1 = sx;
      y1 = sy;
      x2 = ex;
      y2 = ey;
      shown = 1'b0;
      for (int pass = 0; pass <= int'(MAX_PASSES); pass++) begin
        c1 = region(x1, y1);
        c2 = region(x2, y2);
        if ((c1 & c2) != 0) break;
        if ((c1 | c2) == 0) begin
          shown = 1'b1;
          break;
        end
        if (pass == int'(MAX_PASSES)) break;
        if (c1 != 0) move_to_edge(x1, y1, x2, y2, c1);
        else move_to_edge(x2, y2, x1, y1, c2);
      end
      res.visible = shown;
      res.sx = shown ? coord_t'(x1) : '0;
      res.sy = shown ? coord_t'(y1) : '0;
      res.ex = shown ? coord_t'(x2) : '0;
      res.ey = shown ? coord_t'(y2) : '0;
      pending.push_back(res);
      n_segments++;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH result %0d: %s", n_results, msg);
    endtask

    task check_result(logic vis, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      clip_result_t want;
      n_results++;
      if (pending.size() == 0) begin
        report_mismatch("result with no segment outstanding");
        return;
      end
      want = pending.pop_front();
      if (want.visible) n_visible++;
      if (vis !== want.visible)
        report_mismatch($sformatf("visible got %b want %b", vis, want.visible));
      if (sx !== want.sx)
        report_mismatch($sformatf("clip_start_x got %0d want %0d", sx, want.sx));
      if (sy !== want.sy)
        report_mismatch($sformatf("clip_start_y got %0d want %0d", sy, want.sy));
      if (ex !== want.ex)
        report_mismatch($sformatf("clip_end_x got %0d want %0d", ex, want.ex));
      if (ey !== want.ey)
        report_mismatch($sformatf("clip_end_y got %0d want %0d", ey, want.ey));
    endtask
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  cfg_idx_t cfg_idx_i = CFG_XMIN;
  coord_t   cfg_data_i = '0;
  logic     start_i = 1'b0;
  coord_t   start_x_i = '0;
  coord_t   start_y_i = '0;
  coord_t   end_x_i = '0;
  coord_t   end_y_i = '0;
  logic     busy_o, valid_o, visible_o;
  coord_t   clip_start_x_o, clip_start_y_o, clip_end_x_o, clip_end_y_o;

  clip_scoreboard sb;
  int send_idle_pct = 0;
  int windows_loaded = 0;
  int cycle_count = 0;

  line_segment_clipper_unit #(.COORD_BITS(COORD_BITS)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i, .busy_o, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .valid_o, .visible_o, .clip_start_x_o, .clip_start_y_o,
    .clip_end_x_o, .clip_end_y_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_result(visible_o, clip_start_x_o, clip_start_y_o, clip_end_x_o, clip_end_y_o);
  end

  task automatic send_segment(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
        start_i <= 1'b0;
      end else begin
        start_i   <= 1'b1;
        start_x_i <= sx;
        start_y_i <= sy;
        end_x_i   <= ex;
        end_y_i   <= ey;
      end
      @(posedge clk_i);
      if (start_i && !busy_o) begin
        taken = 1'b1;
        sb.note_segment(sx, sy, ex, ey);
      end
    end
  endtask

  // only called with the block idle
  task automatic load_window(input coord_t xmin, input coord_t ymin,
                             input coord_t xmax, input coord_t ymax);
    cfg_idx_t idxs[4];
    coord_t   vals[4];
    idxs = '{CFG_XMIN, CFG_YMIN, CFG_XMAX, CFG_YMAX};
    vals = '{xmin, ymin, xmax, ymax};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      sb.set_edge(idxs[i], vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    windows_loaded++;
  endtask

  task automatic drain(input int tail);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic coord_t clamp_coord(longint v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  // mostly in or near the window span on one axis, sometimes anywhere, at an extreme or on an edge
  function automatic coord_t pick_coord(longint a, longint b);
    longint lo, hi, span, v;
    coord_t r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    span = (hi - lo) / 2 + 8;
    case ($urandom_range(9))
      0, 1: begin
        r = coord_t'($urandom);
        return r;
      end
      2: begin
        case ($urandom_range(3))
          0: return coord_t'(COORD_MIN);
          1: return coord_t'(COORD_MAX);
          2: return coord_t'(a);
          default: return coord_t'(b);
        endcase
      end
      default: begin
        v = longint'($urandom_range(0, int'(hi - lo + 2 * span)));
        return clamp_coord(v + lo - span);
      end
    endcase
  endfunction

  task automatic send_random_segment();
    send_segment(pick_coord(sb.left_edge, sb.right_edge),
                 pick_coord(sb.bottom_edge, sb.top_edge),
                 pick_coord(sb.left_edge, sb.right_edge),
                 pick_coord(sb.bottom_edge, sb.top_edge));
  endtask

  task automatic load_phase_window(input int phase);
    coord_t a, b, c, d;
    longint cx, cy;
    a = coord_t'($urandom);
    b = coord_t'($urandom);
    c = coord_t'($urandom);
    d = coord_t'($urandom);
    case (phase)
      0: load_window(-32768, -32768, 32767, 32767);
      1: load_window(-1000, -500, 1000, 500);
      2: load_window((a < b) ? a : b, (c < d) ? c : d, (a < b) ? b : a, (c < d) ? d : c);
      3: load_window(5, 5, 5, 5);
      4: load_window(200, 100, -200, -100);
      5: begin
        cx = a;
        cy = b;
        load_window(a, b, clamp_coord(cx + $urandom_range(64)),
                    clamp_coord(cy + $urandom_range(64)));
      end
      6: load_window(32000, -32768, 32767, -32000);
      default: load_window(a, b, c, d);
    endcase
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default window after reset
    send_segment(10, 20, 30000, 40);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-100, 50, 100, 50);
    send_segment(100, 50, -100, 50);
    send_segment(50, -100, 50, 100);
    send_segment(-5, -10, -5, 10);
    send_segment(-10, 5, 5, -10);
    send_segment(-1, -1, -1, -1);
    send_segment(0, 0, 0, 0);
    send_segment(32767, 32767, 0, 0);
    send_segment(-32768, 32767, 32767, -32768);
    send_segment(-300, -7, 777, -1);
    send_segment(-7, -300, 1000, 2000);
    send_segment(-32768, 0, -32768, 0);
    send_segment(12345, -32768, -32768, 12345);
    drain(4);

    // min edges above max edges
    load_window(100, 100, -100, -100);
    send_segment(0, 0, 0, 0);
    send_segment(-200, -200, 200, 200);
    send_segment(150, -150, -150, 150);
    send_segment(-150, 0, 150, 0);
    drain(4);

    for (int phase = 0; phase < 8; phase++) begin
      send_idle_pct = (phase < 3) ? 36 : (phase < 6) ? 82 : 0;
      load_phase_window(phase);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_segment();
      drain(4);
    end

    drain(400);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    $display("ran %0d segments under %0d window settings and three sender pacings",
             sb.n_segments, windows_loaded + 1);
    $display("%0d results checked, %0d visible, %0d rejected",
             sb.n_results, sb.n_visible, sb.n_results - sb.n_visible);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
